>>> hdl/uart_baud_divisor_calculator_assert.svh
// ----------------------------------------------------------------------------
// UART baud divisor calculator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALCULATOR_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALCULATOR_ASSERT_SVH

// implication, ignored while reset is high
`define UBDC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubdc assertion failed");

// next-cycle implication, checked through reset as well
`define UBDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ubdc assertion failed");

`endif

>>> hdl/ubdc_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator package
// Widths, stage layout and the per-stage record of the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ubdc_pkg;

  localparam int DIVISOR_BITS = 16;
  localparam int CLK_W   = 27;
  localparam int TOL_W   = 4;
  localparam int BAUD_W  = 22;
  localparam int NUM_W   = 28;
  localparam int DEN_W   = 26;
  localparam int PROD_W  = 35;
  localparam int LHS_W   = 34;
  localparam int DIV_STAGES = NUM_W;
  localparam int ST_PROD = DIV_STAGES + 1;
  localparam int ST_TOL  = DIV_STAGES + 2;
  localparam int ST_OUT  = DIV_STAGES + 3;
  localparam int NSTAGES = DIV_STAGES + 4;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    REG_CLOCK_HZ = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic               zero;
    logic [BAUD_W-1:0]  baud;
    logic [NUM_W-1:0]   num16;
    logic [NUM_W-1:0]   num8;
    logic [DEN_W-1:0]   rem16;
    logic [DEN_W-1:0]   rem8;
    logic [NUM_W-1:0]   quo16;
    logic [NUM_W-1:0]   quo8;
    logic [NUM_W-1:0]   m16;
    logic [NUM_W-1:0]   m8;
    logic [PROD_W-1:0]  hi16;
    logic [PROD_W-1:0]  lo16;
    logic [PROD_W-1:0]  hi8;
    logic [PROD_W-1:0]  lo8;
  } stage_t;

  typedef struct packed {
    logic [15:0] divisor;
    logic        double_speed;
    status_t     status;
  } result_t;

  function automatic status_t tol_status(logic [LHS_W-1:0] lhs, logic [PROD_W-1:0] hi,
                                         logic [PROD_W-1:0] lo);
    status_t s;
    if ({1'b0, lhs} > hi) s = ST_HIGH;
    else if ({1'b0, lhs} < lo) s = ST_LOW;
    else s = ST_OK;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/uart_baud_divisor_calculator.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator
// Rounded x16 divisor with x8 fallback and tolerance status, fully pipelined.
//
//   channel  dir  beat content
//   s_*      in   tdata[21:0] baud_rate
//   m_*      out  tdata[15:0] divisor; tuser[0] double_speed, tuser[2:1] status
//   cfg_*    in   index 0 clock_hz, 1 tolerance_percent; data[26:0]
//
// One beat per cycle while the output is not stalled; one load stage, 28 restoring
// divider stages (one quotient bit each, both divisions side by side),
// one multiply stage, one tolerance product stage and the output register.
// Each stage holds when the one after it is full and held, so a stall
// collapses bubbles and drops nothing. Reset clears valid bits and
// restores clock_hz = 16000000, tolerance_percent = 2.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_baud_divisor_calculator
  import ubdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // baud_rate[21:0], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // divisor[15:0]
  output logic [2:0]       m_tuser,   // status[1:0], double_speed
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [26:0] cfg_data
);

  logic [CLK_W-1:0] clock_hz;
  logic [TOL_W-1:0] tolerance;
  logic [NSTAGES-1:0] v;
  logic [NSTAGES-1:0] adv;
  stage_t st [NSTAGES-1];
  stage_t st_next [NSTAGES-1];
  result_t res;
  result_t res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz  <= CLK_W'(16000000);
      tolerance <= TOL_W'(2);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_CLOCK_HZ:  clock_hz  <= cfg_data;
        REG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv[NSTAGES-1] = !v[NSTAGES-1] || m_tready;
    for (int k = NSTAGES-2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NSTAGES; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // load stage
  always_comb begin
    logic [BAUD_W-1:0] b;
    b = s_tdata[BAUD_W-1:0];
    st_next[0] = '0;
    st_next[0].zero  = (b == '0);
    st_next[0].baud  = b;
    st_next[0].num16 = NUM_W'(clock_hz) + NUM_W'({b, 3'b000});
    st_next[0].num8  = NUM_W'(clock_hz) + NUM_W'({b, 2'b00});
  end

  // restoring division, one quotient bit per stage
  genvar g;
  generate
    for (g = 1; g <= DIV_STAGES; g++) begin : g_div
      always_comb begin
        logic [DEN_W:0] r16;
        logic [DEN_W:0] r8;
        logic [DEN_W:0] d16;
        logic [DEN_W:0] d8;
        st_next[g] = st[g-1];
        d16 = (DEN_W+1)'({st[g-1].baud, 4'b0000});
        d8  = (DEN_W+1)'({st[g-1].baud, 3'b000});
        r16 = {st[g-1].rem16, st[g-1].num16[NUM_W-1]};
        r8  = {st[g-1].rem8,  st[g-1].num8[NUM_W-1]};
        st_next[g].num16 = {st[g-1].num16[NUM_W-2:0], 1'b0};
        st_next[g].num8  = {st[g-1].num8[NUM_W-2:0], 1'b0};
        if (r16 >= d16) begin
          r16 = r16 - d16;
          st_next[g].quo16 = {st[g-1].quo16[NUM_W-2:0], 1'b1};
        end else begin
          st_next[g].quo16 = {st[g-1].quo16[NUM_W-2:0], 1'b0};
        end
        if (r8 >= d8) begin
          r8 = r8 - d8;
          st_next[g].quo8 = {st[g-1].quo8[NUM_W-2:0], 1'b1};
        end else begin
          st_next[g].quo8 = {st[g-1].quo8[NUM_W-2:0], 1'b0};
        end
        st_next[g].rem16 = r16[DEN_W-1:0];
        st_next[g].rem8  = r8[DEN_W-1:0];
      end
    end
  endgenerate

  // achieved-rate products: mult * q * b
  always_comb begin
    logic [NUM_W+BAUD_W-1:0] p16;
    logic [NUM_W+BAUD_W-1:0] p8;
    st_next[ST_PROD] = st[ST_PROD-1];
    p16 = st[ST_PROD-1].quo16 * st[ST_PROD-1].baud;
    p8  = st[ST_PROD-1].quo8 * st[ST_PROD-1].baud;
    st_next[ST_PROD].m16 = {p16[NUM_W-5:0], 4'b0000};
    st_next[ST_PROD].m8  = {p8[NUM_W-4:0], 3'b000};
  end

  // tolerance bounds
  always_comb begin
    logic [6:0] up;
    logic [6:0] dn;
    st_next[ST_TOL] = st[ST_TOL-1];
    up = 7'd100 + 7'(tolerance);
    dn = 7'd100 - 7'(tolerance);
    st_next[ST_TOL].hi16 = PROD_W'(st[ST_TOL-1].m16) * PROD_W'(up);
    st_next[ST_TOL].lo16 = PROD_W'(st[ST_TOL-1].m16) * PROD_W'(dn);
    st_next[ST_TOL].hi8  = PROD_W'(st[ST_TOL-1].m8) * PROD_W'(up);
    st_next[ST_TOL].lo8  = PROD_W'(st[ST_TOL-1].m8) * PROD_W'(dn);
  end

  // decide and saturate
  always_comb begin
    logic [LHS_W-1:0] lhs;
    status_t s16;
    status_t s8;
    status_t s;
    logic [NUM_W-1:0] q;
    logic [NUM_W-1:0] qm1;
    lhs = LHS_W'(clock_hz) * LHS_W'(100);
    s16 = tol_status(lhs, st[ST_OUT-1].hi16, st[ST_OUT-1].lo16);
    s8  = tol_status(lhs, st[ST_OUT-1].hi8, st[ST_OUT-1].lo8);
    res_next.double_speed = (s16 != ST_OK);
    q   = (s16 != ST_OK) ? st[ST_OUT-1].quo8 : st[ST_OUT-1].quo16;
    s   = (s16 != ST_OK) ? s8 : s16;
    qm1 = q - NUM_W'(1);
    if (st[ST_OUT-1].zero) begin
      res_next.divisor = 16'((NUM_W'(1) << DIVISOR_BITS) - NUM_W'(1));
      res_next.double_speed = 1'b0;
      res_next.status = ST_RANGE;
    end else if (q == '0) begin
      res_next.divisor = '0;
      res_next.status = ST_RANGE;
    end else if (q > (NUM_W'(1) << DIVISOR_BITS)) begin
      res_next.divisor = 16'((NUM_W'(1) << DIVISOR_BITS) - NUM_W'(1));
      res_next.status = ST_RANGE;
    end else begin
      res_next.divisor = qm1[15:0];
      res_next.status = s;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGES-1; k++) begin
      if (adv[k]) st[k] <= st_next[k];
    end
    if (adv[ST_OUT]) res <= res_next;
  end

  assign m_tvalid = v[ST_OUT];
  assign m_tdata  = res.divisor;
  assign m_tuser  = {res.status, res.double_speed};

endmodule

`default_nettype wire

>>> hdl/ubdc_checker.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_baud_divisor_calculator_assert.svh"

module ubdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        cfg_ready
);

  `UBDC_ASSERT(out_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
  `UBDC_ASSERT(ready_when_empty, !m_tvalid, s_tready)
  `UBDC_ASSERT_NEXT(empty_after_reset, rst, !m_tvalid)
  `UBDC_ASSERT(cfg_always_ready, s_tvalid || !s_tvalid, cfg_ready)

endmodule

bind uart_baud_divisor_calculator ubdc_checker u_ubdc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator testbench
// Drives baud rate requests through the stream port under several clock and
// tolerance settings and idling and stall phases, predicts divisor, double-speed flag
// and status per request, and compares every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import ubdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 32;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [15:0] divisor;
    logic        double_speed;
    status_t     status;
  } rate_result_t;

  typedef struct {
    logic [21:0] baud;
    bit          known;
    rate_result_t res;
  } baud_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [26:0] cfg_data = '0;

  logic [26:0] clock_hz;
  logic [3:0]  tol_pct;
  rate_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  uart_baud_divisor_calculator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic status_t rate_error(logic [26:0] clk_hz, logic [21:0] b,
                                         logic [3:0] tol, logic [63:0] mult,
                                         logic [63:0] q);
    logic [63:0] lhs, hi, lo;
    lhs = 64'd100 * clk_hz;
    hi = mult * q * (64'd100 * b + b * tol);
    lo = mult * q * (64'd100 * b - b * tol);
    if (lhs > hi) return ST_HIGH;
    if (lhs < lo) return ST_LOW;
    return ST_OK;
  endfunction

  function automatic rate_result_t compute_divisor(logic [21:0] b);
    rate_result_t r;
    logic [63:0] q, dmax;
    dmax = (64'd1 << DIVISOR_BITS) - 1;
    r.double_speed = 1'b0;
    if (b == 0) begin
      r.divisor = dmax[15:0];
      r.status = ST_RANGE;
      return r;
    end
    q = (64'(clock_hz) + 64'd8 * b) / (64'd16 * b);
    r.status = rate_error(clock_hz, b, tol_pct, 64'd16, q);
    if (r.status != ST_OK) begin
      r.double_speed = 1'b1;
      q = (64'(clock_hz) + 64'd4 * b) / (64'd8 * b);
      r.status = rate_error(clock_hz, b, tol_pct, 64'd8, q);
    end
    if (q == 0) begin
      r.divisor = '0;
      r.status = ST_RANGE;
    end else if (q - 1 > dmax) begin
      r.divisor = dmax[15:0];
      r.status = ST_RANGE;
    end else begin
      r.divisor = 16'(q - 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d, expected %0d", results_seen, what, got,
             want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      rate_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result beat, divisor %0d", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.divisor) report_mismatch("divisor", m_tdata, want.divisor);
        if (m_tuser[0] !== want.double_speed)
          report_mismatch("double_speed", m_tuser[0], want.double_speed);
        if (m_tuser[2:1] !== want.status) report_mismatch("status", m_tuser[2:1], want.status);
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("run exceeded cycle limit");
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [26:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CLOCK_HZ) clock_hz = value;
    else tol_pct = value[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the beat until accepted; an idle wait in the next request or drain drops tvalid
  task automatic send_request(input logic [21:0] b, input bit known, input rate_result_t res);
    rate_result_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    want = compute_divisor(b);
    if (known && (want.divisor !== res.divisor || want.double_speed !== res.double_speed ||
                  want.status !== res.status)) begin
      errors++;
      $display("predictor disagrees with table for baud %0d", b);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, b};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(want);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [21:0] random_baud();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      case ($urandom_range(7))
        0: return 22'd300;
        1: return 22'd9600;
        2: return 22'd19200;
        3: return 22'd57600;
        4: return 22'd115200;
        5: return 22'd250000;
        6: return 22'd1000000;
        default: return 22'($urandom_range(1, 2000000));
      endcase
    end
    if (pick < 8) return 22'($urandom_range(1, 4000000));
    return 22'($urandom);
  endfunction

  baud_row_t directed[$];

  initial begin
    rate_result_t none;
    rate_result_t tmp;
    int phase;
    none = '{16'd0, 1'b0, ST_OK};
    clock_hz = 27'd16000000;
    tol_pct = 4'd2;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tmp = '{16'hFFFF, 1'b0, ST_RANGE};
    directed.push_back('{22'd0, 1'b1, tmp});
    tmp = '{16'd16, 1'b1, ST_HIGH};
    directed.push_back('{22'd115200, 1'b1, tmp});
    directed.push_back('{22'd9600, 1'b0, none});
    directed.push_back('{22'd1, 1'b0, none});
    directed.push_back('{22'd4000000, 1'b0, none});
    directed.push_back('{22'h3FFFFF, 1'b0, none});
    directed.push_back('{22'd57600, 1'b0, none});
    directed.push_back('{22'd2000000, 1'b0, none});
    directed.push_back('{22'd250000, 1'b0, none});
    directed.push_back('{22'h155555, 1'b0, none});
    directed.push_back('{22'h2AAAAA, 1'b0, none});
    foreach (directed[i]) send_request(directed[i].baud, directed[i].known, directed[i].res);
    drain();

    write_reg(REG_CLOCK_HZ, 27'h7FFFFFF);
    write_reg(REG_TOLERANCE, 4'd15);
    send_request(22'd1, 1'b0, none);
    send_request(22'd300, 1'b0, none);
    send_request(22'd4000000, 1'b0, none);
    drain();
    write_reg(REG_CLOCK_HZ, 27'd0);
    write_reg(REG_TOLERANCE, 4'd0);
    tmp = '{16'd0, 1'b0, ST_RANGE};
    send_request(22'd9600, 1'b1, tmp);
    send_request(22'd1, 1'b1, tmp);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      case (phase)
        0: write_reg(REG_CLOCK_HZ, 27'd16000000);
        2: write_reg(REG_CLOCK_HZ, 27'd1000000);
        4: write_reg(REG_CLOCK_HZ, 27'd100000000);
        6: write_reg(REG_CLOCK_HZ, 27'($urandom));
        default: write_reg(REG_CLOCK_HZ, 27'($urandom_range(1000000, 100000000)));
      endcase
      write_reg(REG_TOLERANCE, 4'($urandom_range(15)));
      repeat (150) send_request(random_baud(), 1'b0, none);
      drain();
    end

    $display("covered %0d requests and %0d results over eight clock and tolerance settings",
             requests_sent, results_seen);
    $display("including zero, extreme and out-of-range rates with idle and stall phases");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/ubdc_pkg.sv
hdl/uart_baud_divisor_calculator.sv
hdl/ubdc_checker.sv
tb/tb_top.sv
